/* sv/dfdt_pkg.sv */
// Shared constants and helpers for the double to fixed decimal text unit.
`default_nettype none
package dfdt_pkg;
   localparam logic [31:0] INT_LIMIT = 32'd2147483647;
   localparam logic [6:0]  CHAR_ZERO = 7'h30;
   localparam logic [6:0]  CHAR_DOT  = 7'h2E;
   localparam logic [6:0]  CHAR_MINUS = 7'h2D;
   localparam logic [10:0] EXP_SPECIAL = 11'h7FF;
   localparam logic [10:0] EXP_BIAS_SHIFT = 11'd1075;
   localparam logic [10:0] SUBNORM_SHIFT = 11'd1074;
   localparam logic [10:0] ROUND_LIMIT = 11'd90;
   localparam int PROD_W = 84;

   typedef struct packed {
      logic [31:0] quot;
      logic [3:0]  rem;
   } div10_result_type;

   // Ten to the power n, n up to 9.
   function automatic logic [31:0] pow10(input logic [3:0] n);
      logic [31:0] r;
      case (n)
         4'd0: r = 32'd1;
         4'd1: r = 32'd10;
         4'd2: r = 32'd100;
         4'd3: r = 32'd1000;
         4'd4: r = 32'd10000;
         4'd5: r = 32'd100000;
         4'd6: r = 32'd1000000;
         4'd7: r = 32'd10000000;
         4'd8: r = 32'd100000000;
         4'd9: r = 32'd1000000000;
         default: r = 32'd1000000000;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

/* sv/dfdt_div10.sv */
// Divide-by-ten unit: reciprocal multiply, one 32-bit operand per use.
`default_nettype none
module dfdt_div10 (
   input  wire logic [31:0]               x,
   output dfdt_pkg::div10_result_type     result
);
   logic [63:0] prod;
   logic [31:0] q;
   logic [31:0] back;

   always_comb begin
      prod = {32'd0, x} * 64'h0000_0000_CCCC_CCCD;
      q = prod[63:32] >> 3;
      back = (q << 3) + (q << 1);
      result.quot = q;
      result.rem = 4'(x - back);
   end
endmodule
`default_nettype wire

/* sv/double_to_fixed_decimal_text_unit.sv */
// Top level: formats a binary64 value as fixed-point decimal ASCII text.
// Steps: 1 decode + P scale steps + 1 round + INT_DIGITS + P digit steps come before the
// first character is valid (P = effective decimal places), then one character per cycle
// while rsp_stall is low.
// A new request is taken only after the last character of the previous one is loaded.
// The shared divide-by-ten unit and the times-ten accumulator keep the steps serial.
// Reset (synchronous, active high) returns to idle, drops rsp_valid, sets places to 6.
`default_nettype none
module double_to_fixed_decimal_text_unit #(
   parameter int MAX_PLACES = 9,
   parameter int INT_DIGITS = 10
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [63:0] req_value_bits,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [6:0]       rsp_text_char,
   output logic             rsp_last_char,
   output logic             rsp_clipped,
   input  wire logic        csr_wen,
   input  wire logic [3:0]  csr_wdata
);
   localparam int DEPTH = INT_DIGITS + MAX_PLACES;
   localparam int IW = $clog2(DEPTH);
   localparam int PW = dfdt_pkg::PROD_W;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DECODE, ST_SCALE, ST_ROUND, ST_INT, ST_FRAC,
      ST_SIGN, ST_IDIG, ST_DOT, ST_FDIG
   } state_type;

   state_type   state_ff;
   logic [3:0]  places_cfg_ff;
   logic [3:0]  places_ff;
   logic [3:0]  scnt_ff;
   logic [63:0] bits_ff;
   logic [10:0] s_ff;
   logic [PW-1:0] prod_ff;
   logic [52:0] ip_ff;
   logic        clip_ff, nan_ff, neg_ff;
   logic [31:0] x_ff;
   logic [31:0] fr_ff;
   logic [IW-1:0] cnt_ff;
   logic [IW-1:0] ntop_ff;
   logic [3:0]  store_ff [DEPTH];
   logic        out_valid_ff;
   logic [6:0]  out_char_ff;
   logic        out_last_ff;
   logic        out_clip_ff;

   dfdt_pkg::div10_result_type div_res;
   logic [31:0] div_in;

   // Decode signals
   logic [10:0] ex;
   logic [52:0] m;
   logic [10:0] s_dec;
   logic [52:0] ip_dec;
   logic [52:0] f_dec;
   logic [63:0] low_mask;

   // Round signals
   logic [PW-1:0] sh;
   logic [31:0]   fr_raw;
   logic [32:0]   ip_inc;

   logic [3:0]  places_eff;
   logic        out_free;
   logic        out_load;
   logic [IW-1:0] frac_idx;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = out_valid_ff;
   assign rsp_text_char = out_char_ff;
   assign rsp_last_char = out_last_ff;
   assign rsp_clipped = out_clip_ff;
   assign out_free = !out_valid_ff || !rsp_stall;
   // Load a new character whenever an emission state finds the output register free.
   assign out_load = out_free && ((state_ff == ST_SIGN) || (state_ff == ST_IDIG) ||
                                  (state_ff == ST_DOT) || (state_ff == ST_FDIG));

   assign div_in = x_ff;
   dfdt_div10 u_div10 (.x(div_in), .result(div_res));

   always_comb begin
      if (places_cfg_ff == 4'd0) places_eff = 4'd1;
      else if (32'(places_cfg_ff) > MAX_PLACES) places_eff = 4'(MAX_PLACES);
      else places_eff = places_cfg_ff;
   end

   always_comb begin
      ex = bits_ff[62:52];
      m = {(ex != 11'd0), bits_ff[51:0]};
      s_dec = (ex != 11'd0) ? (dfdt_pkg::EXP_BIAS_SHIFT - ex) : dfdt_pkg::SUBNORM_SHIFT;
      ip_dec = (s_dec >= 11'd53) ? 53'd0 : (m >> s_dec[5:0]);
      low_mask = ~(64'hFFFF_FFFF_FFFF_FFFF << s_dec[5:0]);
      f_dec = (s_dec >= 11'd64) ? m : (m & low_mask[52:0]);
   end

   always_comb begin
      sh = prod_ff >> (7'(s_ff) - 7'd1);
      fr_raw = (s_ff >= dfdt_pkg::ROUND_LIMIT) ? 32'd0
             : (32'(sh >> 1) + {31'd0, sh[0]});
      ip_inc = {1'b0, ip_ff[31:0]} + 33'd1;
      frac_idx = IW'(INT_DIGITS + 32'(places_ff) - 1 - 32'(cnt_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         places_cfg_ff <= 4'd6;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) places_cfg_ff <= csr_wdata;
         // Hold the result while stalled, drop it once taken, reload it on a new character.
         out_valid_ff <= out_load || (out_valid_ff && rsp_stall);
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  bits_ff <= req_value_bits;
                  places_ff <= places_eff;
                  state_ff <= ST_DECODE;
               end
            end
            ST_DECODE: begin
               s_ff <= s_dec;
               prod_ff <= PW'(f_dec);
               ip_ff <= ip_dec;
               scnt_ff <= places_ff;
               if (ex == dfdt_pkg::EXP_SPECIAL) begin
                  clip_ff <= 1'b1;
                  nan_ff <= (bits_ff[51:0] != 52'd0);
                  neg_ff <= bits_ff[63] & (bits_ff[51:0] == 52'd0);
                  state_ff <= ST_ROUND;
               end else begin
                  nan_ff <= 1'b0;
                  neg_ff <= bits_ff[63] & (m != 53'd0);
                  clip_ff <= (ex >= dfdt_pkg::EXP_BIAS_SHIFT) ||
                             (ip_dec > 53'(dfdt_pkg::INT_LIMIT));
                  state_ff <= ST_SCALE;
               end
            end
            ST_SCALE: begin
               // Times ten: one shift-add per cycle.
               prod_ff <= (prod_ff << 3) + (prod_ff << 1);
               scnt_ff <= scnt_ff - 4'd1;
               if (scnt_ff == 4'd1) state_ff <= ST_ROUND;
            end
            ST_ROUND: begin
               if (nan_ff) begin
                  x_ff <= 32'd0;
                  fr_ff <= 32'd0;
               end else if (clip_ff) begin
                  x_ff <= dfdt_pkg::INT_LIMIT;
                  fr_ff <= 32'd0;
               end else if (fr_raw >= dfdt_pkg::pow10(places_ff)) begin
                  fr_ff <= 32'd0;
                  if (ip_inc > 33'(dfdt_pkg::INT_LIMIT)) begin
                     x_ff <= dfdt_pkg::INT_LIMIT;
                     clip_ff <= 1'b1;
                  end else begin
                     x_ff <= ip_inc[31:0];
                  end
               end else begin
                  x_ff <= ip_ff[31:0];
                  fr_ff <= fr_raw;
               end
               cnt_ff <= '0;
               ntop_ff <= '0;
               state_ff <= ST_INT;
            end
            ST_INT: begin
               // Integer digits, least significant first.
               store_ff[cnt_ff] <= div_res.rem;
               if (div_res.rem != 4'd0) ntop_ff <= cnt_ff;
               if (32'(cnt_ff) == INT_DIGITS - 1) begin
                  cnt_ff <= '0;
                  x_ff <= fr_ff;
                  state_ff <= ST_FRAC;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
                  x_ff <= div_res.quot;
               end
            end
            ST_FRAC: begin
               // Fraction digits fill from the right end of their field.
               store_ff[frac_idx] <= div_res.rem;
               x_ff <= div_res.quot;
               if (4'(cnt_ff) == places_ff - 4'd1) begin
                  cnt_ff <= ntop_ff;
                  state_ff <= neg_ff ? ST_SIGN : ST_IDIG;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_SIGN: begin
               if (out_free) begin
                  out_char_ff <= dfdt_pkg::CHAR_MINUS;
                  out_last_ff <= 1'b0;
                  out_clip_ff <= clip_ff;
                  state_ff <= ST_IDIG;
               end
            end
            ST_IDIG: begin
               if (out_free) begin
                  out_char_ff <= dfdt_pkg::CHAR_ZERO + {3'd0, store_ff[cnt_ff]};
                  out_last_ff <= 1'b0;
                  out_clip_ff <= clip_ff;
                  if (cnt_ff == '0) state_ff <= ST_DOT;
                  else cnt_ff <= cnt_ff - 1'b1;
               end
            end
            ST_DOT: begin
               if (out_free) begin
                  out_char_ff <= dfdt_pkg::CHAR_DOT;
                  out_last_ff <= 1'b0;
                  out_clip_ff <= clip_ff;
                  cnt_ff <= '0;
                  state_ff <= ST_FDIG;
               end
            end
            ST_FDIG: begin
               if (out_free) begin
                  out_char_ff <= dfdt_pkg::CHAR_ZERO +
                                 {3'd0, store_ff[IW'(INT_DIGITS + 32'(cnt_ff))]};
                  out_clip_ff <= clip_ff;
                  if (4'(cnt_ff) == places_ff - 4'd1) begin
                     out_last_ff <= 1'b1;
                     state_ff <= ST_IDLE;
                  end else begin
                     out_last_ff <= 1'b0;
                     cnt_ff <= cnt_ff + 1'b1;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

/* test/tb_top.sv */
// Testbench for the double to fixed decimal text unit: random and directed requests, checked text.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

   typedef struct packed {
      logic [6:0] text_char;
      logic       last_char;
      logic       clipped;
   } text_item_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [63:0] req_value_bits;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [6:0]  rsp_text_char;
   logic        rsp_last_char;
   logic        rsp_clipped;
   logic        csr_wen;
   logic [3:0]  csr_wdata;

   double_to_fixed_decimal_text_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_value_bits(req_value_bits),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_text_char(rsp_text_char),
      .rsp_last_char(rsp_last_char), .rsp_clipped(rsp_clipped),
      .csr_wen(csr_wen), .csr_wdata(csr_wdata)
   );

   localparam int WATCHDOG_LIMIT = 20000;

   // Shared state between stimulus, driver and monitor.
   logic [63:0]    pending_values[$];
   text_item_type  expected_text[$];
   logic [3:0]     places_reg;
   int             send_idle_pct;
   int             stall_pct;
   int             error_count;
   int             quiet_cycles;
   logic           req_taken = 1'b0;

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Format one value as the block should, appending its characters to the expectation queue.
   task automatic predict_text(input logic [63:0] bits);
      logic        sign;
      logic [10:0] ex;
      logic [52:0] mant;
      logic [63:0] ip;
      logic [63:0] fr;
      logic [63:0] frac;
      logic [127:0] prod;
      logic [63:0] tenp;
      logic        clip;
      logic        neg;
      int          places;
      int          shift;
      int          nint;
      logic [3:0]  int_digits[10];
      logic [3:0]  frac_digits[9];
      logic [63:0] tmp;
      text_item_type t;
      places = (places_reg < 1) ? 1 : (places_reg > 9) ? 9 : int'(places_reg);
      tenp = 1;
      for (int i = 0; i < places; i++) tenp = tenp * 10;
      sign = bits[63];
      ex = bits[62:52];
      clip = 1'b0;
      neg = 1'b0;
      ip = 0;
      fr = 0;
      if (ex == dfdt_pkg::EXP_SPECIAL) begin
         clip = 1'b1;
         if (bits[51:0] == 0) begin
            neg = sign;
            ip = dfdt_pkg::INT_LIMIT;
         end
      end else begin
         mant = (ex != 0) ? {1'b1, bits[51:0]} : {1'b0, bits[51:0]};
         if (mant != 0) begin
            neg = sign;
            if (ex >= 11'd1075) begin
               clip = 1'b1;
            end else begin
               shift = (ex != 0) ? 1075 - int'(ex) : 1074;
               ip = (shift >= 53) ? 64'd0 : 64'(mant >> shift);
               frac = (shift >= 64) ? 64'(mant) : 64'(mant) & ((64'd1 << shift) - 1);
               if (ip > dfdt_pkg::INT_LIMIT) begin
                  clip = 1'b1;
               end else if (shift < 90) begin
                  // Exact product, then round half away from zero at bit shift.
                  prod = 128'(frac) * 128'(tenp);
                  fr = 64'(prod >> shift) + 64'((prod >> (shift - 1)) & 1);
               end
            end
         end
         if (clip) begin
            ip = dfdt_pkg::INT_LIMIT;
            fr = 0;
         end
         if (fr >= tenp) begin
            fr = 0;
            ip = ip + 1;
            if (ip > dfdt_pkg::INT_LIMIT) begin
               ip = dfdt_pkg::INT_LIMIT;
               clip = 1'b1;
            end
         end
      end
      nint = 1;
      tmp = ip;
      for (int i = 0; i < 10; i++) begin
         int_digits[i] = 4'(tmp % 10);
         tmp = tmp / 10;
         if (int_digits[i] != 0) nint = i + 1;
      end
      tmp = fr;
      for (int i = places - 1; i >= 0; i--) begin
         frac_digits[i] = 4'(tmp % 10);
         tmp = tmp / 10;
      end
      t.clipped = clip;
      t.last_char = 1'b0;
      if (neg) begin
         t.text_char = dfdt_pkg::CHAR_MINUS;
         expected_text.push_back(t);
      end
      for (int i = nint - 1; i >= 0; i--) begin
         t.text_char = dfdt_pkg::CHAR_ZERO + 7'(int_digits[i]);
         expected_text.push_back(t);
      end
      t.text_char = dfdt_pkg::CHAR_DOT;
      expected_text.push_back(t);
      for (int i = 0; i < places; i++) begin
         t.text_char = dfdt_pkg::CHAR_ZERO + 7'(frac_digits[i]);
         t.last_char = (i == places - 1);
         expected_text.push_back(t);
      end
   endtask

   // Driver: present the oldest pending request, hold it until it is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // hold payload
      end else if (pending_values.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
         req_valid <= 1'b1;
         req_value_bits <= pending_values.pop_front();
      end else begin
         req_valid <= 1'b0;
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Monitor: predict on accepted requests, check accepted characters.
   always @(posedge clock) begin
      text_item_type got;
      text_item_type want;
      req_taken <= req_valid && !req_stall && !reset;
      if (!reset) begin
         if (req_valid && !req_stall) predict_text(req_value_bits);
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_text_char, rsp_last_char, rsp_clipped};
            if (expected_text.size() == 0) begin
               $display("%0t: unexpected char expected none actual %h", $time, got);
               error_count++;
            end else begin
               want = expected_text.pop_front();
               if (got.text_char !== want.text_char) begin
                  $display("%0t: text_char expected %h actual %h", $time,
                     want.text_char, got.text_char);
                  error_count++;
               end
               if (got.last_char !== want.last_char) begin
                  $display("%0t: last_char expected %b actual %b", $time,
                     want.last_char, got.last_char);
                  error_count++;
               end
               if (got.clipped !== want.clipped) begin
                  $display("%0t: clipped expected %b actual %b", $time,
                     want.clipped, got.clipped);
                  error_count++;
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Watchdog: end the run if nothing moves for too long.
   always @(posedge clock) begin
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Wait until every request has gone in and every character has come out.
   task automatic drain();
      while (pending_values.size() > 0 || req_valid) @(posedge clock);
      while (expected_text.size() > 0) @(posedge clock);
   endtask

   // Change the places register while the block sits idle.
   task automatic write_places(input logic [3:0] value);
      drain();
      @(negedge clock);
      csr_wen <= 1'b1;
      csr_wdata <= value;
      places_reg = value;
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   function automatic logic [63:0] random_value();
      logic [63:0] v;
      int          pick;
      v = {$urandom, $urandom};
      pick = $urandom_range(9);
      // Mostly exponents that give a readable integer part and a live fraction.
      if (pick < 6) v[62:52] = 11'($urandom_range(1050, 990));
      else if (pick == 6) v[62:52] = 11'($urandom_range(1086, 1050));
      else if (pick == 7) v[62:52] = 11'h7FF;
      else if (pick == 8) v[62:52] = 11'($urandom_range(2));
      return v;
   endfunction

   initial begin
      logic [63:0] directed[$];
      reset = 1'b1;
      req_valid = 1'b0;
      req_value_bits = '0;
      rsp_stall = 1'b0;
      csr_wen = 1'b0;
      csr_wdata = 4'd0;
      places_reg = 4'd6;
      send_idle_pct = 0;
      stall_pct = 0;
      error_count = 0;
      quiet_cycles = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: zeros, signs, specials, subnormals, carries, saturation.
      directed = '{64'h0000000000000000, 64'h8000000000000000, 64'h3FD0000000000000,
         64'hBFD0000000000000, 64'h7FF0000000000000, 64'hFFF0000000000000,
         64'h7FF8000000000000, 64'hFFFFFFFFFFFFFFFF, 64'h0000000000000001,
         64'h800FFFFFFFFFFFFF, 64'h3FEFFFFFFFFFFFFF, 64'hBFEFFFFFFFFFFFFF,
         64'h41DFFFFFFFC00000, 64'h41DFFFFFFFFFFFFF, 64'hC1E0000000000000,
         64'h41E0000000000000, 64'h7FEFFFFFFFFFFFFF, 64'h3FF8000000000000,
         64'h4024000000000000, 64'h3EB0C6F7A0B5ED8D, 64'hBE7AD7F29ABCAF48};
      foreach (directed[i]) pending_values.push_back(directed[i]);
      drain();
      // Sender pauses here until every character is back.

      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 59; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 59; end
            default: begin send_idle_pct = 6; stall_pct = 6; end
         endcase
         case (phase)
            0: write_places(4'd1);
            1: write_places(4'd9);
            2: write_places(4'd0);
            3: write_places(4'd15);
            default: write_places(4'($urandom_range(15)));
         endcase
         for (int i = 0; i < 17; i++) pending_values.push_back(random_value());
         drain();
         repeat (60) @(posedge clock);
      end

      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
`default_nettype wire

/* filelist.f */
sv/dfdt_pkg.sv
sv/dfdt_div10.sv
sv/double_to_fixed_decimal_text_unit.sv
test/tb_top.sv
